/* rtl/gapped_sorted_table_search_macros.svh */
// ----------------------------------------------------------------------------
// Gapped sorted table search: assertion macros
// Clocked on i_clk and quiet while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GAPPED_SORTED_TABLE_SEARCH_MACROS_SVH
`define GAPPED_SORTED_TABLE_SEARCH_MACROS_SVH

// same-cycle implication
`define GSTS_AST_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GSTS_AST_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/gsts_pkg.sv */
// ----------------------------------------------------------------------------
// Gapped sorted table search: shared package
// Field widths, command and status codes, controller/datapath structs.
// ----------------------------------------------------------------------------
package gsts_pkg;

    localparam int SLOTS_DEF = 1024;
    localparam int KEY_W     = 32;
    localparam int POS_W     = 10;
    localparam int STAT_W    = 2;
    localparam int OP_W      = 2;
    localparam int SPREAD_W  = 5;
    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 32;

    typedef logic [OP_W-1:0]   t_op;
    typedef logic [STAT_W-1:0] t_stat;
    typedef logic [1:0]        t_psel;

    localparam t_op OP_LOAD    = 2'd0;
    localparam t_op OP_SEARCH  = 2'd1;
    localparam t_op OP_REMOVE  = 2'd2;
    localparam t_op OP_RESTART = 2'd3;

    localparam t_stat ST_OK   = 2'd0;
    localparam t_stat ST_MISS = 2'd1;
    localparam t_stat ST_FULL = 2'd2;

    localparam t_psel PSEL_ZERO = 2'd0;
    localparam t_psel PSEL_LP   = 2'd1;
    localparam t_psel PSEL_MID  = 2'd2;

    localparam logic REG_SPREAD = 1'b0;

    typedef struct packed {
        logic  accept;
        logic  load_wr;
        logic  load_fin;
        logic  restart;
        logic  rd_h;
        logic  h_dbl;
        logic  h_clip;
        logic  h_dec;
        logic  bin_init;
        logic  rd_mid;
        logic  lo_up;
        logic  e_dn;
        logic  finish;
        logic  clr;
        t_stat res_st;
        t_psel res_pos;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic full;
        logic load_last;
        logic grow;
        logic back_more;
        logic bin_go;
        logic hit;
        logic less;
    } t_sts;

endpackage

/* rtl/gsts_cfg.sv */
// ----------------------------------------------------------------------------
// Gapped sorted table search: register port
// APB-style slave holding the spread register.
// ----------------------------------------------------------------------------
module gsts_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gsts_pkg::CFG_AW-1:0]     paddr,
    input  logic [gsts_pkg::CFG_DW-1:0]     pwdata,
    output logic [gsts_pkg::CFG_DW-1:0]     prdata,
    output logic                            pready,
    output logic [gsts_pkg::SPREAD_W-1:0]   o_spread
);

    logic                          spread_hit;
    logic [gsts_pkg::SPREAD_W-1:0] r_spread;

    assign spread_hit = (paddr[gsts_pkg::CFG_AW-1:2] == gsts_pkg::REG_SPREAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spread <= gsts_pkg::SPREAD_W'(1);
        end else if (psel && penable && pwrite && spread_hit) begin
            r_spread <= pwdata[gsts_pkg::SPREAD_W-1:0];
        end
    end

    assign prdata   = spread_hit ? gsts_pkg::CFG_DW'(r_spread) : '0;
    assign pready   = 1'b1;
    assign o_spread = r_spread;

endmodule

/* rtl/gsts_dpath.sv */
// ----------------------------------------------------------------------------
// Gapped sorted table search: datapath
// Key table RAM, load pointer, high-water mark, search bounds and result.
// ----------------------------------------------------------------------------
module gsts_dpath #(
    parameter int SLOTS = gsts_pkg::SLOTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [gsts_pkg::OP_W-1:0]           i_cmd,
    input  logic signed [gsts_pkg::KEY_W-1:0]   i_key,
    input  logic [gsts_pkg::SPREAD_W-1:0]       i_spread,
    input  gsts_pkg::t_cmd                      i_ctl,
    output gsts_pkg::t_sts                      o_sts,
    output logic                                o_done,
    output logic [gsts_pkg::STAT_W-1:0]         o_status,
    output logic [gsts_pkg::POS_W-1:0]          o_position
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = AW + 1;
    localparam int KW = gsts_pkg::KEY_W;
    localparam int SW = gsts_pkg::SPREAD_W;
    localparam int PW = gsts_pkg::POS_W;

    logic [KW:0]                r_mem [SLOTS];
    gsts_pkg::t_op              r_op;
    logic signed [KW-1:0]       r_key;
    logic [CW-1:0]              r_lp;
    logic [CW-1:0]              r_hwm;
    logic [SW-1:0]              r_j;
    logic [AW-1:0]              r_h;
    logic [CW-1:0]              r_lo;
    logic [CW-1:0]              r_e;
    logic [KW:0]                r_rd_word;
    logic                       r_rd_zero;
    logic                       r_done;
    gsts_pkg::t_stat            r_status;
    logic [PW-1:0]              r_pos;

    logic [SW-1:0]              n_s;
    logic [CW-1:0]              n_s_ext;
    logic [CW-1:0]              n_wr_full;
    logic [CW-1:0]              n_end;
    logic [CW-1:0]              n_dbl;
    logic [CW:0]                n_sum;
    logic [AW-1:0]              n_mid;
    logic [AW-1:0]              n_rd_addr;
    logic signed [KW-1:0]       n_v;
    logic                       n_vld;
    logic                       n_we;
    logic [AW-1:0]              n_waddr;
    logic [KW:0]                n_wdata;
    logic [CW+PW-1:0]           n_pos_lp;
    logic [AW+PW-1:0]           n_pos_mid;
    logic [PW-1:0]              n_pos;

    assign n_s       = (i_spread == '0) ? SW'(1) : i_spread;
    assign n_s_ext   = CW'(n_s);
    assign n_wr_full = r_lp + CW'(r_j);
    assign n_end     = r_lp + n_s_ext;
    assign n_dbl     = {r_h, 1'b0};
    assign n_sum     = (CW+1)'(r_lo) + (CW+1)'(r_e) - (CW+1)'(1);
    assign n_mid     = n_sum[AW:1];
    assign n_rd_addr = i_ctl.rd_mid ? n_mid : r_h;

    assign n_v   = r_rd_zero ? '0 : $signed(r_rd_word[KW-1:0]);
    assign n_vld = !r_rd_zero && r_rd_word[KW];

    assign n_we    = i_ctl.load_wr || i_ctl.clr;
    assign n_waddr = i_ctl.load_wr ? n_wr_full[AW-1:0] : n_mid;
    assign n_wdata = i_ctl.load_wr ? {(r_j == '0), r_key} : {1'b0, r_key};

    assign n_pos_lp  = (CW+PW)'(r_lp);
    assign n_pos_mid = (AW+PW)'(n_mid);

    always_comb begin
        unique case (i_ctl.res_pos)
            gsts_pkg::PSEL_LP:  n_pos = n_pos_lp[PW-1:0];
            gsts_pkg::PSEL_MID: n_pos = n_pos_mid[PW-1:0];
            default:            n_pos = '0;
        endcase
    end

    assign o_sts.op        = r_op;
    assign o_sts.full      = n_s_ext > (CW'(SLOTS) - r_lp);
    assign o_sts.load_last = (r_j == n_s - SW'(1));
    assign o_sts.grow      = (n_v != '0) && (r_key > n_v) && (CW'(r_h) < CW'(SLOTS - 1));
    assign o_sts.back_more = (r_h != '0) && (n_v == '0);
    assign o_sts.bin_go    = r_lo < r_e;
    assign o_sts.hit       = n_vld && (n_v == r_key);
    assign o_sts.less      = n_v < r_key;

    // table RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_mem[n_waddr] <= n_wdata;
        end
        if (i_ctl.rd_h || i_ctl.rd_mid) begin
            r_rd_word <= r_mem[n_rd_addr];
        end
    end

    // slots at or above the high-water mark were never written: they read empty
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_h || i_ctl.rd_mid) begin
            r_rd_zero <= CW'(n_rd_addr) >= r_hwm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_op  <= i_cmd;
            r_key <= i_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp  <= '0;
            r_hwm <= '0;
        end else if (i_ctl.load_fin) begin
            r_lp <= n_end;
            if (n_end > r_hwm) begin
                r_hwm <= n_end;
            end
        end else if (i_ctl.restart) begin
            r_lp <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_j <= '0;
        end else if (i_ctl.load_wr) begin
            r_j <= r_j + SW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_ctl.accept) begin
            r_h <= AW'(1);
        end else if (i_ctl.h_dbl) begin
            r_h <= (n_dbl > CW'(SLOTS - 1)) ? AW'(SLOTS - 1) : n_dbl[AW-1:0];
        end else if (i_ctl.h_clip) begin
            if (CW'(r_h) >= r_hwm) begin
                r_h <= (r_hwm == '0) ? '0 : AW'(r_hwm - CW'(1));
            end
        end else if (i_ctl.h_dec) begin
            r_h <= r_h - AW'(1);
        end else begin
            r_h <= r_h;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_ctl.bin_init) begin
            r_lo <= '0;
            r_e  <= CW'(r_h) + CW'(1);
        end else if (i_ctl.lo_up) begin
            r_lo <= CW'(n_mid) + CW'(1);
        end else if (i_ctl.e_dn) begin
            r_e <= CW'(n_mid);
        end else begin
            r_lo <= r_lo;
            r_e  <= r_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_ctl.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            r_status <= i_ctl.res_st;
            r_pos    <= n_pos;
        end
    end

    assign o_done     = r_done;
    assign o_status   = r_status;
    assign o_position = r_pos;

endmodule

/* rtl/gsts_ctrl.sv */
// ----------------------------------------------------------------------------
// Gapped sorted table search: controller
// Sequences load writes, range doubling, backward scan and binary search.
// ----------------------------------------------------------------------------
module gsts_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    input  gsts_pkg::t_sts  i_sts,
    output gsts_pkg::t_cmd  o_ctl
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DISP    = 4'd1;
    localparam logic [3:0] S_LOAD    = 4'd2;
    localparam logic [3:0] S_BND_RD  = 4'd3;
    localparam logic [3:0] S_BND_EV  = 4'd4;
    localparam logic [3:0] S_BCK_CLP = 4'd5;
    localparam logic [3:0] S_BCK_RD  = 4'd6;
    localparam logic [3:0] S_BCK_EV  = 4'd7;
    localparam logic [3:0] S_BIN_CHK = 4'd8;
    localparam logic [3:0] S_BIN_EV  = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_ctl   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.accept = 1'b1;
                    n_state      = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_sts.op)
                    gsts_pkg::OP_LOAD: begin
                        if (i_sts.full) begin
                            o_ctl.finish  = 1'b1;
                            o_ctl.res_st  = gsts_pkg::ST_FULL;
                            o_ctl.res_pos = gsts_pkg::PSEL_ZERO;
                            n_state       = S_IDLE;
                        end else begin
                            n_state = S_LOAD;
                        end
                    end
                    gsts_pkg::OP_SEARCH, gsts_pkg::OP_REMOVE: begin
                        o_ctl.rd_h = 1'b1;
                        n_state    = S_BND_EV;
                    end
                    default: begin
                        o_ctl.restart = 1'b1;
                        o_ctl.finish  = 1'b1;
                        o_ctl.res_st  = gsts_pkg::ST_OK;
                        o_ctl.res_pos = gsts_pkg::PSEL_ZERO;
                        n_state       = S_IDLE;
                    end
                endcase
            end
            S_LOAD: begin
                o_ctl.load_wr = 1'b1;
                if (i_sts.load_last) begin
                    o_ctl.load_fin = 1'b1;
                    o_ctl.finish   = 1'b1;
                    o_ctl.res_st   = gsts_pkg::ST_OK;
                    o_ctl.res_pos  = gsts_pkg::PSEL_LP;
                    n_state        = S_IDLE;
                end
            end
            S_BND_RD: begin
                o_ctl.rd_h = 1'b1;
                n_state    = S_BND_EV;
            end
            S_BND_EV: begin
                if (i_sts.grow) begin
                    o_ctl.h_dbl = 1'b1;
                    n_state     = S_BND_RD;
                end else begin
                    n_state = S_BCK_CLP;
                end
            end
            S_BCK_CLP: begin
                o_ctl.h_clip = 1'b1;
                n_state      = S_BCK_RD;
            end
            S_BCK_RD: begin
                o_ctl.rd_h = 1'b1;
                n_state    = S_BCK_EV;
            end
            S_BCK_EV: begin
                if (i_sts.back_more) begin
                    o_ctl.h_dec = 1'b1;
                    n_state     = S_BCK_RD;
                end else begin
                    o_ctl.bin_init = 1'b1;
                    n_state        = S_BIN_CHK;
                end
            end
            S_BIN_CHK: begin
                if (i_sts.bin_go) begin
                    o_ctl.rd_mid = 1'b1;
                    n_state      = S_BIN_EV;
                end else begin
                    o_ctl.finish  = 1'b1;
                    o_ctl.res_st  = gsts_pkg::ST_MISS;
                    o_ctl.res_pos = gsts_pkg::PSEL_ZERO;
                    n_state       = S_IDLE;
                end
            end
            S_BIN_EV: begin
                priority if (i_sts.hit) begin
                    o_ctl.finish  = 1'b1;
                    o_ctl.clr     = (i_sts.op == gsts_pkg::OP_REMOVE);
                    o_ctl.res_st  = gsts_pkg::ST_OK;
                    o_ctl.res_pos = gsts_pkg::PSEL_MID;
                    n_state       = S_IDLE;
                end else if (i_sts.less) begin
                    o_ctl.lo_up = 1'b1;
                    n_state     = S_BIN_CHK;
                end else begin
                    o_ctl.e_dn = 1'b1;
                    n_state    = S_BIN_CHK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

/* rtl/gapped_sorted_table_search.sv */
// ----------------------------------------------------------------------------
// Gapped sorted table search: top level
// One word at a time; the result strobe o_done lasts one cycle and cannot be
// stalled. busy falls in the cycle the result shows, so the next start is
// taken then. Restart and a load into a full table finish at dispatch; a
// load writes one RAM word per slot of the spread. Search and remove read
// the range bound while it doubles (about log2 SLOTS reads), clip the bound
// to the written region, scan backward (one slot read, plus one per
// zero-keyed slot below the bound, so many loaded zero keys make this scan
// long), then probe by binary search (about log2 SLOTS more probes) until
// a hit or an empty range, which is a miss. No clearing pass after reset:
// slots at or above the high-water mark of loads read as empty.
// ----------------------------------------------------------------------------
`include "gapped_sorted_table_search_macros.svh"

module gapped_sorted_table_search #(
    parameter int SLOTS = gsts_pkg::SLOTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [gsts_pkg::OP_W-1:0]           i_cmd,
    input  logic signed [gsts_pkg::KEY_W-1:0]   i_key,
    output logic                                o_done,
    output logic [gsts_pkg::STAT_W-1:0]         o_status,
    output logic [gsts_pkg::POS_W-1:0]          o_position,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gsts_pkg::CFG_AW-1:0]         paddr,
    input  logic [gsts_pkg::CFG_DW-1:0]         pwdata,
    output logic [gsts_pkg::CFG_DW-1:0]         prdata,
    output logic                                pready
);

    logic [gsts_pkg::SPREAD_W-1:0] spread;
    gsts_pkg::t_cmd                ctl;
    gsts_pkg::t_sts                sts;

    gsts_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_spread (spread)
    );

    gsts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    gsts_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_cmd),
        .i_key      (i_key),
        .i_spread   (spread),
        .i_ctl      (ctl),
        .o_sts      (sts),
        .o_done     (o_done),
        .o_status   (o_status),
        .o_position (o_position)
    );

    `GSTS_AST_NXT(a_start_busy, i_start && !o_busy, o_busy, "accepted word did not raise busy")
    `GSTS_AST_IMP(a_done_idle, o_done, !o_busy, "result shown while still busy")
    `GSTS_AST_NXT(a_done_single, o_done, !o_done, "result strobe longer than one cycle")
    `GSTS_AST_IMP(a_fail_pos, o_done && (o_status != gsts_pkg::ST_OK), o_position == '0, "nonzero position on failure")

endmodule
